/* hdl/psb_pkg.sv */
// Shared types, constants and helper functions of the pixel saturation/brightness block.
package psb_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MagW    = 16;
  localparam int unsigned QuoW    = 10;
  localparam int unsigned SumW    = 11;

  // Pipeline depth from input beat to output register (both stage modules)
  localparam int unsigned PipeDepth = 7;

  localparam logic [PixW-1:0] ChanMax = 8'hff;
  localparam logic [8:0]      Percent = 9'd100;

  // x / 100 == (x * 83887) >> 23 for every x below 2**16
  localparam logic [16:0]     RecipMul   = 17'd83887;
  localparam int unsigned     RecipShift = 23;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSat = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBri = 2'd1;

  // Pixel as carried on tdata: red in the lowest byte, alpha in the highest
  typedef struct packed {
    logic [PixW-1:0] a;
    logic [PixW-1:0] b;
    logic [PixW-1:0] g;
    logic [PixW-1:0] r;
  } pix_t;

  // Color channels as lanes: 0 red, 1 green, 2 blue
  typedef logic [NumChan-1:0][PixW-1:0] chan_t;

  function automatic logic [PixW-1:0] min3(input chan_t c);
    logic [PixW-1:0] m;
    m = (c[0] < c[1]) ? c[0] : c[1];
    return (m < c[2]) ? m : c[2];
  endfunction

  function automatic logic [PixW-1:0] max3(input chan_t c);
    logic [PixW-1:0] m;
    m = (c[0] > c[1]) ? c[0] : c[1];
    return (m > c[2]) ? m : c[2];
  endfunction

  // Truncating divide by 100 of a nonnegative magnitude
  function automatic logic [QuoW-1:0] div100(input logic [MagW-1:0] m);
    logic [MagW+RecipShift-7:0] p;
    p = {{(RecipShift-6){1'b0}}, m} * {{(MagW+RecipShift-23){1'b0}}, RecipMul};
    return p[MagW+RecipShift-7 -: QuoW];
  endfunction

  // Clamp a signed sum to 0..255
  function automatic logic [PixW-1:0] clamp8(input logic signed [SumW-1:0] v);
    logic [PixW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({3'b000, ChanMax})) begin
      r = ChanMax;
    end else begin
      r = v[PixW-1:0];
    end
    return r;
  endfunction

  // Signed add of a magnitude to a channel, sign chosen by neg
  function automatic logic signed [SumW-1:0] add_mag(input logic [PixW-1:0] base,
                                                     input logic [QuoW-1:0] mag,
                                                     input logic neg);
    logic [SumW-1:0] m;
    m = {1'b0, mag};
    if (neg) begin
      m = '0 - m;
    end
    return $signed({3'b000, base} + m);
  endfunction

endpackage

/* hdl/psb_sat.sv */
// Saturation pipeline: min/max, stretch multiply, divide by 100, clamp (four stages).
module psb_sat import psb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pix_t                   in_pix_i,
  input  logic signed [PixW-1:0] sat_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pix_t                   out_pix_o
);

  chan_t           in_ch;
  logic [PixW-1:0] in_mx, in_mn;
  logic [8:0]      fac, fac_neg;
  logic            fneg;
  logic [PixW-1:0] fabs;
  logic            bypass;

  logic rdy_a, rdy_b, rdy_c, rdy_d;

  logic            a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  chan_t           a_ch_q, b_ch_q, c_ch_q, d_ch_q;
  logic [PixW-1:0] a_alpha_q, b_alpha_q, c_alpha_q, d_alpha_q;
  logic [PixW-1:0] a_mn_q, b_mn_q, c_mn_q;
  logic            a_bypass_q, b_bypass_q, c_bypass_q;
  logic            a_fneg_q, b_fneg_q, c_fneg_q;
  logic [PixW-1:0] a_fabs_q;

  logic [NumChan-1:0][MagW-1:0] b_mag_d, b_mag_q;
  logic [NumChan-1:0][QuoW-1:0] c_quo_d, c_quo_q;
  chan_t                        d_ch_d;

  // Stall chain: a stage takes a beat when empty or when its successor moves
  assign rdy_d      = !d_vld_q || out_ready_i;
  assign rdy_c      = !c_vld_q || rdy_d;
  assign rdy_b      = !b_vld_q || rdy_c;
  assign rdy_a      = !a_vld_q || rdy_b;
  assign in_ready_o = rdy_a;

  // Stage A front: channel extremes, stretch factor and skip decision
  assign in_ch   = {in_pix_i.b, in_pix_i.g, in_pix_i.r};
  assign in_mx   = max3(in_ch);
  assign in_mn   = min3(in_ch);
  assign fac     = {sat_i[PixW-1], sat_i} + Percent;
  assign fac_neg = 9'd0 - fac;
  assign fneg    = fac[8];
  assign fabs    = fneg ? fac_neg[PixW-1:0] : fac[PixW-1:0];
  assign bypass  = (sat_i == '0) ||
                   (!sat_i[PixW-1] && (in_mx == ChanMax)) ||
                   (sat_i[PixW-1] && (in_mx == '0));

  // Stage B front: distance from the minimum times the factor magnitude
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      b_mag_d[i] = {8'd0, a_ch_q[i] - a_mn_q} * {8'd0, a_fabs_q};
    end
  end

  // Stage C front: divide each product by 100
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      c_quo_d[i] = div100(b_mag_q[i]);
    end
  end

  // Stage D front: offset from the minimum and clamp, or hold the source
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      d_ch_d[i] = c_bypass_q ? c_ch_q[i] : clamp8(add_mag(c_mn_q, c_quo_q[i], c_fneg_q));
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (rdy_a) a_vld_q <= in_valid_i;
      if (rdy_b) b_vld_q <= a_vld_q;
      if (rdy_c) c_vld_q <= b_vld_q;
      if (rdy_d) d_vld_q <= c_vld_q;
    end
  end

  // Payload registers advance with their stage
  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      a_ch_q     <= in_ch;
      a_alpha_q  <= in_pix_i.a;
      a_mn_q     <= in_mn;
      a_bypass_q <= bypass;
      a_fneg_q   <= fneg;
      a_fabs_q   <= fabs;
    end
    if (rdy_b) begin
      b_ch_q     <= a_ch_q;
      b_alpha_q  <= a_alpha_q;
      b_mn_q     <= a_mn_q;
      b_bypass_q <= a_bypass_q;
      b_fneg_q   <= a_fneg_q;
      b_mag_q    <= b_mag_d;
    end
    if (rdy_c) begin
      c_ch_q     <= b_ch_q;
      c_alpha_q  <= b_alpha_q;
      c_mn_q     <= b_mn_q;
      c_bypass_q <= b_bypass_q;
      c_fneg_q   <= b_fneg_q;
      c_quo_q    <= c_quo_d;
    end
    if (rdy_d) begin
      d_ch_q     <= d_ch_d;
      d_alpha_q  <= c_alpha_q;
    end
  end

  assign out_valid_o = d_vld_q;
  assign out_pix_o   = '{a: d_alpha_q, b: d_ch_q[2], g: d_ch_q[1], r: d_ch_q[0]};

endmodule

/* hdl/psb_bright.sv */
// Brightness pipeline: headroom multiply, divide by 100, add and clamp (three stages).
module psb_bright import psb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pix_t                   in_pix_i,
  input  logic signed [PixW-1:0] bri_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pix_t                   out_pix_o
);

  chan_t           in_ch;
  logic [PixW-1:0] in_mn, head, babs;
  logic            bneg;
  logic [MagW-1:0] e_mag_d;

  logic rdy_e, rdy_f, rdy_g;

  logic            e_vld_q, f_vld_q, g_vld_q;
  chan_t           e_ch_q, f_ch_q, g_ch_q;
  logic [PixW-1:0] e_alpha_q, f_alpha_q, g_alpha_q;
  logic            e_bneg_q, f_bneg_q;
  logic [MagW-1:0] e_mag_q;
  logic [QuoW-1:0] f_quo_q;
  chan_t           g_ch_d;

  // Stall chain
  assign rdy_g      = !g_vld_q || out_ready_i;
  assign rdy_f      = !f_vld_q || rdy_g;
  assign rdy_e      = !e_vld_q || rdy_f;
  assign in_ready_o = rdy_e;

  // Stage E front: headroom above the new minimum times the percent magnitude
  assign in_ch   = {in_pix_i.b, in_pix_i.g, in_pix_i.r};
  assign in_mn   = min3(in_ch);
  assign head    = ChanMax - in_mn;
  assign bneg    = bri_i[PixW-1];
  assign babs    = bneg ? (8'd0 - bri_i) : bri_i;
  assign e_mag_d = {8'd0, head} * {8'd0, babs};

  // Stage G front: apply the common offset to every lane and clamp
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      g_ch_d[i] = clamp8(add_mag(f_ch_q[i], f_quo_q, f_bneg_q));
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
    end else begin
      if (rdy_e) e_vld_q <= in_valid_i;
      if (rdy_f) f_vld_q <= e_vld_q;
      if (rdy_g) g_vld_q <= f_vld_q;
    end
  end

  // Payload registers advance with their stage
  always_ff @(posedge clk_i) begin
    if (rdy_e) begin
      e_ch_q    <= in_ch;
      e_alpha_q <= in_pix_i.a;
      e_bneg_q  <= bneg;
      e_mag_q   <= e_mag_d;
    end
    if (rdy_f) begin
      f_ch_q    <= e_ch_q;
      f_alpha_q <= e_alpha_q;
      f_bneg_q  <= e_bneg_q;
      f_quo_q   <= div100(e_mag_q);
    end
    if (rdy_g) begin
      g_ch_q    <= g_ch_d;
      g_alpha_q <= f_alpha_q;
    end
  end

  assign out_valid_o = g_vld_q;
  assign out_pix_o   = '{a: g_alpha_q, b: g_ch_q[2], g: g_ch_q[1], r: g_ch_q[0]};

endmodule

/* hdl/pixel_saturation_brightness.sv */
// Top level of the pixel saturation and brightness adjuster.
//
// Usage: pixels enter on the s_axis stream, one beat per pixel, and leave on
// the m_axis stream in the same order, one beat per pixel. tdata packs red,
// green, blue and alpha from the lowest byte up; alpha passes unchanged.
// Two signed percent registers, saturation (index 0) and brightness
// (index 1), are written on the cfg channel, which is always ready; a write
// to any other index is dropped. Write them only while no pixel is in flight.
// From an input beat to its output beat a pixel passes four stages of
// saturation (extremes, stretch multiply, reciprocal divide, clamp) and
// three of brightness (headroom multiply, reciprocal divide, add and clamp).
// Throughput is one pixel per clock while the receiver is ready, set by
// the fully pipelined multiplier lanes. Every stage has its own valid bit,
// so when the receiver stalls the output beat holds, empty stages upstream
// still fill, and s_axis_tready falls only once all seven stages hold pixels.
// Reset clears all valid bits and both registers to zero (both adjustments
// off, pixels pass unchanged).
module pixel_saturation_brightness import psb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [4*PixW-1:0]  s_axis_tdata_i,   // red_in, green_in, blue_in, alpha_in
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [4*PixW-1:0]  m_axis_tdata_o,   // red_out, green_out, blue_out, alpha_out
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PixW-1:0]    cfg_data_i
);

  logic signed [PixW-1:0] sat_q, bri_q;
  pix_t                   in_pix, mid_pix, out_pix;
  logic                   mid_valid, mid_ready;

  // Configuration registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= '0;
      bri_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSat:  sat_q <= $signed(cfg_data_i);
        CfgBri:  bri_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign in_pix = s_axis_tdata_i;

  psb_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_pix_i    (in_pix),
    .sat_i       (sat_q),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_pix_o   (mid_pix)
  );

  psb_bright u_bright (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_pix_i    (mid_pix),
    .bri_i       (bri_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_pix_o   (out_pix)
  );

  assign m_axis_tdata_o = out_pix;

endmodule

/* hdl/psb_chk.sv */
// Port-level checker for the pixel saturation and brightness adjuster, with its bind.
module psb_chk import psb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [4*PixW-1:0]  m_axis_tdata_o
);

  logic [3:0] occ_d, occ_q;
  logic       in_beat, out_beat;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  // Track pixels in flight
  always_comb begin
    occ_d = occ_q;
    if (in_beat)  occ_d = occ_d + 4'd1;
    if (out_beat) occ_d = occ_d - 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat dropped or changed while stalled");

  // No output beat without a pixel in flight
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> occ_q != 4'd0)
    else $error("output beat without a matching input beat");

  // Never more pixels in flight than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 4'(PipeDepth))
    else $error("more pixels in flight than pipeline stages");

  // A ready receiver lets the input stream run
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while the receiver is ready");

endmodule

bind pixel_saturation_brightness psb_chk u_psb_chk (.*);

/* dv/tb_pixel_saturation_brightness.sv */
// Testbench of the pixel saturation and brightness adjuster: directed rows, then random pixels.
module tb_pixel_saturation_brightness;
  import psb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Unused register indexes; writes to them must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  localparam int ChanTop     = 255;
  localparam int PctScale    = 100;
  localparam int NumRows     = 21;
  localparam int NumSegs     = 14;
  localparam int SegPixels   = 100;
  localparam int StallLimit  = 1000;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [4*PixW-1:0]  s_axis_tdata_i;   // red_in, green_in, blue_in, alpha_in
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [4*PixW-1:0]  m_axis_tdata_o;   // red_out, green_out, blue_out, alpha_out
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [PixW-1:0]    cfg_data_i;

  pixel_saturation_brightness dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // One directed pixel: register setting, source pixel, and a golden
  // output where it is obvious by hand
  typedef struct {
    int          sat;
    int          bri;
    logic [31:0] px;
    bit          has_gold;
    logic [31:0] gold;
  } pix_row_t;

  // Pixels are {alpha, blue, green, red}
  pix_row_t dir_rows [NumRows] = '{
    '{   0,    0, 32'h00000000, 1'b1, 32'h00000000},
    '{   0,    0, 32'hffffffff, 1'b1, 32'hffffffff},
    '{   0,    0, 32'h78563412, 1'b1, 32'h78563412},
    // stretch skipped: brightest channel already full
    '{  50,    0, 32'h3c140aff, 1'b1, 32'h3c140aff},
    // desaturation skipped: black pixel
    '{ -50,    0, 32'h81000000, 1'b1, 32'h81000000},
    '{ 100,    0, 32'h5a003264, 1'b1, 32'h5a0064c8},
    // full desaturation collapses to the minimum channel
    '{-100,    0, 32'h113264c8, 1'b1, 32'h11323232},
    // register values beyond the percent range
    '{ 127,    0, 32'h000a1464, 1'b0, 32'h0},
    '{-128,    0, 32'hff3264c8, 1'b0, 32'h0},
    '{-128,    0, 32'h020000fa, 1'b0, 32'h0},
    '{ 127,    0, 32'h7f0000c8, 1'b0, 32'h0},
    '{   0,  100, 32'h40000000, 1'b1, 32'h40ffffff},
    '{   0, -100, 32'hc3ffffff, 1'b1, 32'hc3ffffff},
    '{   0, -100, 32'h2a0080ff, 1'b1, 32'h2a000000},
    '{   0,  127, 32'h5564c80a, 1'b0, 32'h0},
    '{   0, -128, 32'h5564c80a, 1'b0, 32'h0},
    // negative shift truncates toward zero
    '{   0,   -1, 32'h99643200, 1'b0, 32'h0},
    '{   1,    1, 32'h10c98e25, 1'b0, 32'h0},
    '{  -1,   -1, 32'h10c98e25, 1'b0, 32'h0},
    '{  50,  -30, 32'hee8000ff, 1'b0, 32'h0},
    '{-100,  100, 32'h01010000, 1'b1, 32'h01ffffff}
  };

  pix_t        expected_pixels [$];
  int          sat_now;
  int          bri_now;
  int          mismatch_count;
  int          stall_cycles;
  int unsigned src_gap_pct;
  int unsigned snk_gap_pct;
  bit          gold_valid;
  pix_t        gold_next;
  pix_t        want;
  pix_t        got;

  function automatic int chan_min(input int c [3]);
    int m;
    m = (c[0] < c[1]) ? c[0] : c[1];
    return (m < c[2]) ? m : c[2];
  endfunction

  function automatic int clip_chan(input int v);
    if (v < 0) return 0;
    if (v > ChanTop) return ChanTop;
    return v;
  endfunction

  // Adjusted pixel for a source pixel under the given register setting
  function automatic pix_t predict_pixel(input int sat, input int bri, input pix_t src);
    int   ch [3];
    int   hi;
    int   lo;
    int   shift;
    pix_t res;
    ch[0] = int'(src.r);
    ch[1] = int'(src.g);
    ch[2] = int'(src.b);
    // Stretch or compress each channel's distance from the minimum
    if (sat != 0) begin
      hi = ch[0];
      foreach (ch[i]) if (ch[i] > hi) hi = ch[i];
      lo = chan_min(ch);
      if (!((sat > 0 && hi == ChanTop) || (sat < 0 && hi == 0))) begin
        foreach (ch[i]) ch[i] = clip_chan(lo + ((ch[i] - lo) * (PctScale + sat)) / PctScale);
      end
    end
    // Shift all channels by a share of the headroom above the new minimum
    if (bri != 0) begin
      shift = ((ChanTop - chan_min(ch)) * bri) / PctScale;
      foreach (ch[i]) ch[i] = clip_chan(ch[i] + shift);
    end
    res.r = ch[0][PixW-1:0];
    res.g = ch[1][PixW-1:0];
    res.b = ch[2][PixW-1:0];
    res.a = src.a;
    return res;
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p = pix_t'($urandom);
    case ($urandom_range(7))
      // gray
      0: begin
        p.g = p.r;
        p.b = p.r;
      end
      1: p.r = ChanMax;
      2: p.g = '0;
      // nearly black
      3: begin
        p.r = PixW'($urandom_range(1));
        p.g = PixW'($urandom_range(2));
        p.b = PixW'($urandom_range(1));
      end
      4: p.b = ChanMax - 8'd1;
      default: ;
    endcase
    return p;
  endfunction

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(99) >= snk_gap_pct);
  end

  // Shadow registers, expectations and output checks
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgSat:  sat_now = int'($signed(cfg_data_i));
          CfgBri:  bri_now = int'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = pix_t'(m_axis_tdata_o);
        if (expected_pixels.size() == 0) begin
          $error("output beat %h with no pixel outstanding", m_axis_tdata_o);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.r !== want.r) begin
            $error("red_out: expected %0d, got %0d", want.r, got.r);
            mismatch_count++;
          end
          if (got.g !== want.g) begin
            $error("green_out: expected %0d, got %0d", want.g, got.g);
            mismatch_count++;
          end
          if (got.b !== want.b) begin
            $error("blue_out: expected %0d, got %0d", want.b, got.b);
            mismatch_count++;
          end
          if (got.a !== want.a) begin
            $error("alpha_out: expected %0d, got %0d", want.a, got.a);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (gold_valid) begin
          expected_pixels.push_back(gold_next);
        end else begin
          expected_pixels.push_back(predict_pixel(sat_now, bri_now, pix_t'(s_axis_tdata_i)));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("tb_pixel_saturation_brightness failed");
        $finish;
      end
    end
  end

  // Offer one pixel, with random idle cycles first, and hold it until taken
  task automatic send_pixel(input pix_t p, input bit has_gold, input pix_t gold);
    @(negedge clk_i);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = p;
    gold_valid      = has_gold;
    gold_next       = gold;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PixW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Stop sending, wait out every outstanding pixel, then let the pipe settle
  task automatic drain_pipe();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (PipeDepth + 2) @(negedge clk_i);
  endtask

  initial begin
    int cur_sat;
    int cur_bri;
    int sat_corner [6];
    int bri_corner [6];
    sat_corner = '{-128, -100, 0, 100, 127, -1};
    bri_corner = '{-1, 127, 100, 0, -100, -128};
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CfgSat;
    cfg_data_i      = '0;
    gold_valid      = 1'b0;
    gold_next       = '0;
    sat_now         = 0;
    bri_now         = 0;
    mismatch_count  = 0;
    stall_cycles    = 0;
    src_gap_pct     = 34;
    snk_gap_pct     = 53;
    rst_ni          = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; reconfigure only when the row asks for a new setting
    cur_sat = 0;
    cur_bri = 0;
    foreach (dir_rows[i]) begin
      if (i == 1) begin
        // poke the unused indexes; the passthrough rows that follow show they were dropped
        drain_pipe();
        write_reg(CfgSpare2, 8'h64);
        write_reg(CfgSpare3, 8'h9c);
      end
      if (dir_rows[i].sat != cur_sat || dir_rows[i].bri != cur_bri) begin
        drain_pipe();
        write_reg(CfgSat, 8'(dir_rows[i].sat));
        write_reg(CfgBri, 8'(dir_rows[i].bri));
        cur_sat = dir_rows[i].sat;
        cur_bri = dir_rows[i].bri;
      end
      send_pixel(pix_t'(dir_rows[i].px), dir_rows[i].has_gold, pix_t'(dir_rows[i].gold));
    end

    // Random segments, each under its own register setting
    for (int seg = 0; seg < NumSegs; seg++) begin
      if (seg < 5) begin
        src_gap_pct = 34;
        snk_gap_pct = 53;
      end else if (seg < 10) begin
        src_gap_pct = 53;
        snk_gap_pct = 34;
      end else begin
        src_gap_pct = 0;
        snk_gap_pct = 0;
      end
      if (seg < 6) begin
        cur_sat = sat_corner[seg];
        cur_bri = bri_corner[seg];
      end else begin
        cur_sat = $urandom_range(1) ? int'($signed(8'($urandom))) : $urandom_range(200) - 100;
        cur_bri = $urandom_range(1) ? int'($signed(8'($urandom))) : $urandom_range(200) - 100;
      end
      drain_pipe();
      write_reg(CfgSat, 8'(cur_sat));
      write_reg(CfgBri, 8'(cur_bri));
      write_reg($urandom_range(1) ? CfgSpare2 : CfgSpare3, 8'($urandom));
      repeat (SegPixels) send_pixel(rand_pixel(), 1'b0, '0);
    end

    drain_pipe();
    if (mismatch_count == 0) begin
      $display("tb_pixel_saturation_brightness passed");
    end else begin
      $display("tb_pixel_saturation_brightness failed");
    end
    $finish;
  end

endmodule
